// ===== rtl/depthwise_deconv_3x3_scatter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the depthwise deconvolution scatter block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEPTHWISE_DECONV_3X3_SCATTER_TOP_MACROS_SVH
`define DEPTHWISE_DECONV_3X3_SCATTER_TOP_MACROS_SVH

// Check a property on every clock edge
`define DDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define DDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types, codes and widths of the depthwise deconvolution scatter block.
// ----------------------------------------------------------------------------
package dds_pkg;

	// Field widths
	localparam int ACT_W      = 2;
	localparam int WIDX_W     = 4;
	localparam int PIX_W      = 16;
	localparam int WGT_W      = 16;
	localparam int PROD_W     = 32;
	localparam int ACC_W      = 48;
	localparam int RC_W       = 7;
	localparam int DIM_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int TAPS       = 9;
	localparam int TAP_W      = 4;

	// Default image limits
	localparam int MAX_IN_W_DEF = 32;
	localparam int MAX_IN_H_DEF = 32;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ACC  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [DIM_W-1:0] DIM_RST = 6'd32;

	// Kernel geometry
	localparam logic [TAP_W-1:0] TAP_LAST = 4'd8;
	localparam logic [1:0]       KCOL_LAST = 2'd2;

	// Saturation limits
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_RD_ISSUE,
		ST_RD_DATA
	} state_t;

	// Tap issued to the multiply-accumulate stage
	typedef struct packed {
		logic                    vld;
		logic signed [PIX_W-1:0] pixel;
		logic signed [WGT_W-1:0] weight;
	} tap_ctl_t;

endpackage

// ===== rtl/dds_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_if
// Valid/ready channels of the scatter block: request, response, configuration.
// ----------------------------------------------------------------------------

// Request channel: weight load, pixel accumulate, read and clear
interface dds_req_if;
	logic                                   valid;
	logic                                   ready;
	logic        [dds_pkg::ACT_W-1:0]       action;
	logic        [dds_pkg::WIDX_W-1:0]      weight_index;
	logic signed [dds_pkg::WGT_W-1:0]       weight_value;
	logic signed [dds_pkg::PIX_W-1:0]       pixel_value;
	logic        [dds_pkg::RC_W-1:0]        read_row;
	logic        [dds_pkg::RC_W-1:0]        read_col;

	modport source (output valid, action, weight_index, weight_value, pixel_value,
		read_row, read_col, input ready);
	modport sink (input valid, action, weight_index, weight_value, pixel_value,
		read_row, read_col, output ready);
endinterface

// Response channel: one beat per read
interface dds_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [dds_pkg::ACC_W-1:0]  out_value;
	logic                              range_error;

	modport source (output valid, out_value, range_error, input ready);
	modport sink (input valid, out_value, range_error, output ready);
endinterface

// Configuration write channel
interface dds_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [dds_pkg::CFG_IDX_W-1:0]      index;
	logic [dds_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dds_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dds_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4225,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/dds_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_mac
// Tap multiply and saturating accumulate: product registered alongside the
// memory read, then added to the read data and written back.
// ----------------------------------------------------------------------------
module dds_mac #(
	parameter int AW = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dds_pkg::tap_ctl_t          tap,
	input  logic [AW-1:0]              tap_addr,
	input  logic [dds_pkg::ACC_W-1:0]  rdata,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [dds_pkg::ACC_W-1:0]  wr_data
);

	logic                                vld_s1;
	logic [AW-1:0]                       addr_s1;
	logic signed [dds_pkg::PROD_W-1:0]   prod_s1;
	logic signed [dds_pkg::ACC_W:0]      sum;

	// Track the tap in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tap.vld;
		end
	end

	// Register product and address while the memory reads
	always_ff @(posedge clk) begin
		if (tap.vld) begin
			addr_s1 <= tap_addr;
			prod_s1 <= tap.pixel * tap.weight;
		end
	end

	// Add exactly, then clamp to the accumulator range
	always_comb begin
		sum = (dds_pkg::ACC_W + 1)'($signed(rdata)) + (dds_pkg::ACC_W + 1)'(prod_s1);
		if (sum[dds_pkg::ACC_W] != sum[dds_pkg::ACC_W-1]) begin
			wr_data = sum[dds_pkg::ACC_W] ? dds_pkg::ACC_MIN : dds_pkg::ACC_MAX;
		end else begin
			wr_data = sum[dds_pkg::ACC_W-1:0];
		end
	end

	assign wr_en   = vld_s1;
	assign wr_addr = addr_s1;

endmodule

// ===== rtl/dds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_ctrl
// Sequencer: configuration, kernel weights, raster position, tap issue,
// read-and-clear, output register and the clearing pass after reset.
// ----------------------------------------------------------------------------
module dds_ctrl #(
	parameter int MAX_IN_W = dds_pkg::MAX_IN_W_DEF,
	parameter int MAX_IN_H = dds_pkg::MAX_IN_H_DEF,
	localparam int OUT_MAX_W = (MAX_IN_W - 1) * 2 + 3,
	localparam int OUT_MAX_H = (MAX_IN_H - 1) * 2 + 3,
	localparam int DEPTH     = OUT_MAX_W * OUT_MAX_H,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dds_cfg_if.sink                    cfg,
	dds_req_if.sink                    req,
	dds_rsp_if.source                  rsp,
	input  logic                       mac_busy,
	output dds_pkg::tap_ctl_t          tap,
	output logic                       ram_re,
	output logic [AW-1:0]              ram_raddr,
	input  logic [dds_pkg::ACC_W-1:0]  ram_rdata,
	output logic                       ram_we,
	output logic [AW-1:0]              ram_waddr
);

	// Position and size widths
	localparam int PCW = (MAX_IN_W > 1) ? $clog2(MAX_IN_W) : 1;
	localparam int PRW = (MAX_IN_H > 1) ? $clog2(MAX_IN_H) : 1;
	localparam int SWW = $clog2(MAX_IN_W + 1);
	localparam int SHW = $clog2(MAX_IN_H + 1);
	localparam int CWW = (SWW > dds_pkg::DIM_W) ? SWW : dds_pkg::DIM_W;
	localparam int CHW = (SHW > dds_pkg::DIM_W) ? SHW : dds_pkg::DIM_W;
	localparam int OCW = $clog2(OUT_MAX_W);
	localparam int ORW = $clog2(OUT_MAX_H);
	localparam int OWW = $clog2(OUT_MAX_W + 1);
	localparam int OHW = $clog2(OUT_MAX_H + 1);
	localparam int RCW = (OWW > dds_pkg::RC_W) ? OWW : dds_pkg::RC_W;
	localparam int RRW = (OHW > dds_pkg::RC_W) ? OHW : dds_pkg::RC_W;

	dds_pkg::state_t state_q, state_d;

	// Configuration registers
	logic                          stride_q;
	logic [dds_pkg::DIM_W-1:0]     cfg_w_q;
	logic [dds_pkg::DIM_W-1:0]     cfg_h_q;

	logic signed [dds_pkg::WGT_W-1:0] weight_q [dds_pkg::TAPS];

	// Raster position of the next pixel
	logic [PCW-1:0] pcol_q;
	logic [PRW-1:0] prow_q;

	// Current pixel and tap counters
	logic [PCW-1:0]                   base_c_q;
	logic [PRW-1:0]                   base_r_q;
	logic signed [dds_pkg::PIX_W-1:0] pixel_q;
	logic [dds_pkg::TAP_W-1:0]        tap_q;
	logic [1:0]                       tr_q;
	logic [1:0]                       tc_q;

	// Read request
	logic [AW-1:0] rd_addr_q;
	logic          rd_err_q;

	logic [AW-1:0] clr_q;

	// Output register
	logic                             out_vld_q;
	logic signed [dds_pkg::ACC_W-1:0] out_value_q;
	logic                             out_err_q;

	logic           accept;
	logic           cfg_hit;
	logic           out_load;
	logic [SWW-1:0] eff_w;
	logic [SHW-1:0] eff_h;
	logic [OWW-1:0] ow;
	logic [OHW-1:0] oh;
	logic           rd_oob;
	logic           pos_out;
	logic           col_end;
	logic           row_end;
	logic [PCW-1:0] cur_c;
	logic [PRW-1:0] cur_r;
	logic [PCW-1:0] nxt_c;
	logic [PRW-1:0] nxt_r;
	logic [OCW-1:0] ocol;
	logic [ORW-1:0] orow;
	logic [AW-1:0]  tap_addr;
	logic [AW-1:0]  req_addr;

	assign accept  = req.valid && req.ready;
	assign cfg_hit = cfg.valid && cfg.ready && (cfg.index == dds_pkg::CFG_STRIDE ||
		cfg.index == dds_pkg::CFG_WIDTH || cfg.index == dds_pkg::CFG_HEIGHT);
	assign cfg.ready = 1'b1;

	// Clamp the image size to 1..max
	always_comb begin
		if (cfg_w_q == '0) begin
			eff_w = SWW'(1);
		end else if (CWW'(cfg_w_q) > CWW'(MAX_IN_W)) begin
			eff_w = SWW'(MAX_IN_W);
		end else begin
			eff_w = SWW'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			eff_h = SHW'(1);
		end else if (CHW'(cfg_h_q) > CHW'(MAX_IN_H)) begin
			eff_h = SHW'(MAX_IN_H);
		end else begin
			eff_h = SHW'(cfg_h_q);
		end
	end

	// Output size and range check of a read
	always_comb begin
		ow       = ((OWW'(eff_w) - OWW'(1)) << stride_q) + OWW'(3);
		oh       = ((OHW'(eff_h) - OHW'(1)) << stride_q) + OHW'(3);
		rd_oob   = (RRW'(req.read_row) >= RRW'(oh)) || (RCW'(req.read_col) >= RCW'(ow));
		req_addr = AW'(req.read_row) * AW'(OUT_MAX_W) + AW'(req.read_col);
	end

	// Step the raster position past the accepted pixel
	always_comb begin
		pos_out = (SWW'(pcol_q) >= eff_w) || (SHW'(prow_q) >= eff_h);
		cur_c   = pos_out ? '0 : pcol_q;
		cur_r   = pos_out ? '0 : prow_q;
		col_end = (SWW'(cur_c) + SWW'(1)) >= eff_w;
		row_end = (SHW'(cur_r) + SHW'(1)) >= eff_h;
		nxt_c   = col_end ? '0 : cur_c + PCW'(1);
		if (col_end) begin
			nxt_r = row_end ? '0 : cur_r + PRW'(1);
		end else begin
			nxt_r = cur_r;
		end
	end

	// Address of the current tap
	always_comb begin
		orow     = (ORW'(base_r_q) << stride_q) + ORW'(tr_q);
		ocol     = (OCW'(base_c_q) << stride_q) + OCW'(tc_q);
		tap_addr = AW'(orow) * AW'(OUT_MAX_W) + AW'(ocol);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dds_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = dds_pkg::ST_IDLE;
				end
			end
			dds_pkg::ST_IDLE: begin
				if (accept && req.action == dds_pkg::ACT_ACC) begin
					state_d = dds_pkg::ST_ACC;
				end else if (accept && req.action == dds_pkg::ACT_READ) begin
					state_d = dds_pkg::ST_RD_ISSUE;
				end
			end
			dds_pkg::ST_ACC: begin
				if (tap_q == dds_pkg::TAP_LAST) begin
					state_d = dds_pkg::ST_IDLE;
				end
			end
			dds_pkg::ST_RD_ISSUE: begin
				state_d = dds_pkg::ST_RD_DATA;
			end
			dds_pkg::ST_RD_DATA: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = dds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dds_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs per state
	always_comb begin
		req.ready  = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = tap_addr;
		ram_we     = 1'b0;
		ram_waddr  = rd_addr_q;
		tap.vld    = 1'b0;
		tap.pixel  = pixel_q;
		tap.weight = weight_q[tap_q];
		out_load   = 1'b0;
		unique case (state_q)
			dds_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			dds_pkg::ST_IDLE: begin
				req.ready = !mac_busy;
			end
			dds_pkg::ST_ACC: begin
				ram_re  = 1'b1;
				tap.vld = 1'b1;
			end
			dds_pkg::ST_RD_ISSUE: begin
				ram_re    = !rd_err_q;
				ram_raddr = rd_addr_q;
			end
			dds_pkg::ST_RD_DATA: begin
				out_load = !out_vld_q || rsp.ready;
				ram_we   = out_load && !rd_err_q;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dds_pkg::ST_CLEAR;
			clr_q     <= '0;
			stride_q  <= 1'b0;
			cfg_w_q   <= dds_pkg::DIM_RST;
			cfg_h_q   <= dds_pkg::DIM_RST;
			pcol_q    <= '0;
			prow_q    <= '0;
			tap_q     <= '0;
			tr_q      <= '0;
			tc_q      <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < dds_pkg::TAPS; i++) begin
				weight_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			// Sweep the accumulator memory after reset
			if (state_q == dds_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			// Take configuration writes; a write to a real register restarts the raster
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					dds_pkg::CFG_STRIDE: stride_q <= cfg.data[0];
					dds_pkg::CFG_WIDTH:  cfg_w_q  <= cfg.data;
					dds_pkg::CFG_HEIGHT: cfg_h_q  <= cfg.data;
					default: ;
				endcase
			end

			if (cfg_hit) begin
				pcol_q <= '0;
				prow_q <= '0;
			end else if (accept && req.action == dds_pkg::ACT_ACC) begin
				pcol_q <= nxt_c;
				prow_q <= nxt_r;
			end

			// Load a weight, drop bad indexes
			if (accept && req.action == dds_pkg::ACT_LOAD &&
				req.weight_index < dds_pkg::WIDX_W'(dds_pkg::TAPS)) begin
				weight_q[req.weight_index] <= req.weight_value;
			end

			// Advance the tap counters
			if (accept) begin
				tap_q <= '0;
				tr_q  <= '0;
				tc_q  <= '0;
			end else if (state_q == dds_pkg::ST_ACC) begin
				tap_q <= tap_q + dds_pkg::TAP_W'(1);
				if (tc_q == dds_pkg::KCOL_LAST) begin
					tc_q <= '0;
					tr_q <= tr_q + 2'd1;
				end else begin
					tc_q <= tc_q + 2'd1;
				end
			end

			// Hold the result until taken
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			base_c_q  <= cur_c;
			base_r_q  <= cur_r;
			pixel_q   <= req.pixel_value;
			rd_addr_q <= req_addr;
			rd_err_q  <= rd_oob;
		end
		if (out_load) begin
			out_value_q <= rd_err_q ? '0 : $signed(ram_rdata);
			out_err_q   <= rd_err_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.out_value   = out_value_q;
	assign rsp.range_error = out_err_q;

endmodule

// ===== rtl/depthwise_deconv_3x3_scatter_top.sv =====
`timescale 1ns / 1ps
// Sequence: a weight load leaves the block in IDLE; a read passes ST_RD_ISSUE and ST_RD_DATA
//   before its beat is registered. Requests are taken one at a time: a pixel holds off the next
//   through 9 tap read-modify-writes on the single read port of the accumulator RAM and a write-back.
// Reset: arst_n clears registers and weights, then a clearing pass writes all
//   OUT_MAX_H*OUT_MAX_W entries (4225 at 32x32) to zero with req.ready low.
// ----------------------------------------------------------------------------
// depthwise_deconv_3x3_scatter_top
// 3x3 transposed convolution of one channel, stride 1 or 2, scattering
// saturated 48-bit sums into an accumulator RAM that reads clear.
// ----------------------------------------------------------------------------
module depthwise_deconv_3x3_scatter_top #(
	parameter int MAX_IN_W = dds_pkg::MAX_IN_W_DEF,
	parameter int MAX_IN_H = dds_pkg::MAX_IN_H_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dds_cfg_if.sink    cfg,
	dds_req_if.sink    req,
	dds_rsp_if.source  rsp
);

	localparam int OUT_MAX_W = (MAX_IN_W - 1) * 2 + 3;
	localparam int OUT_MAX_H = (MAX_IN_H - 1) * 2 + 3;
	localparam int DEPTH     = OUT_MAX_W * OUT_MAX_H;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	dds_pkg::tap_ctl_t          tap;
	logic                       ctl_re;
	logic [AW-1:0]              ctl_raddr;
	logic                       ctl_we;
	logic [AW-1:0]              ctl_waddr;
	logic                       mac_we;
	logic [AW-1:0]              mac_waddr;
	logic [dds_pkg::ACC_W-1:0]  mac_wdata;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [dds_pkg::ACC_W-1:0]  ram_wdata;
	logic [dds_pkg::ACC_W-1:0]  ram_rdata;

	dds_ctrl #(
		.MAX_IN_W (MAX_IN_W),
		.MAX_IN_H (MAX_IN_H)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.rsp       (rsp),
		.mac_busy  (mac_we),
		.tap       (tap),
		.ram_re    (ctl_re),
		.ram_raddr (ctl_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ctl_we),
		.ram_waddr (ctl_waddr)
	);

	dds_mac #(
		.AW (AW)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.tap      (tap),
		.tap_addr (ctl_raddr),
		.rdata    (ram_rdata),
		.wr_en    (mac_we),
		.wr_addr  (mac_waddr),
		.wr_data  (mac_wdata)
	);

	// Select the write: tap write-back, else clear from the sequencer
	always_comb begin
		ram_we    = mac_we || ctl_we;
		ram_waddr = mac_we ? mac_waddr : ctl_waddr;
		ram_wdata = mac_we ? mac_wdata : '0;
	end

	dds_ram #(
		.WIDTH (dds_pkg::ACC_W),
		.DEPTH (DEPTH)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl_re),
		.raddr (ctl_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== rtl/dds_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_chk
// Port-level checks of the scatter block, bound to the top level.
// ----------------------------------------------------------------------------
`include "depthwise_deconv_3x3_scatter_top_macros.svh"

module dds_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic [dds_pkg::ACT_W-1:0]         req_action,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [dds_pkg::ACC_W-1:0]  rsp_out_value,
	input logic                              rsp_range_error
);

	// A pixel occupies the sequencer after its beat
	`DDS_ASSERT_NEXT(a_acc_busy, req_valid && req_ready && req_action == dds_pkg::ACT_ACC, !req_ready, "ready after pixel beat")

	// A weight load leaves the block ready
	`DDS_ASSERT_NEXT(a_load_ready, req_valid && req_ready && req_action == dds_pkg::ACT_LOAD, req_ready, "not ready after weight load")

	// An out-of-range read carries a zero value
	`DDS_ASSERT(a_err_zero, rsp_valid && rsp_range_error |-> rsp_out_value == '0, "range error with nonzero value")

	// A response beat holds until taken
	`DDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

endmodule

bind depthwise_deconv_3x3_scatter_top dds_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_action      (req.action),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_out_value   (rsp.out_value),
	.rsp_range_error (rsp.range_error)
);

// ===== sim/depthwise_deconv_3x3_scatter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depthwise_deconv_3x3_scatter_top_tb
// Self-checking bench for the 3x3 transposed convolution scatter block. A
// scoreboard keeps its own copy of the kernel, the 65x65 accumulator plane
// and the raster position, predicts every read beat and compares it field by
// field. Directed beats cover the field extremes and the corner cases; random
// phases then load kernels, stream whole or broken channel images and drain
// the output, under random idling on both the request and response sides.
// ----------------------------------------------------------------------------

// One request beat as the bench builds it
typedef struct packed {
	logic        [dds_pkg::ACT_W-1:0]  action;
	logic        [dds_pkg::WIDX_W-1:0] weight_index;
	logic signed [dds_pkg::WGT_W-1:0]  weight_value;
	logic signed [dds_pkg::PIX_W-1:0]  pixel_value;
	logic        [dds_pkg::RC_W-1:0]   read_row;
	logic        [dds_pkg::RC_W-1:0]   read_col;
} req_beat_t;

// One expected read beat
typedef struct packed {
	logic signed [dds_pkg::ACC_W-1:0] value;
	logic                             range_error;
} read_result_t;

class deconv_scoreboard;
	localparam int     MAX_W   = dds_pkg::MAX_IN_W_DEF;
	localparam int     MAX_H   = dds_pkg::MAX_IN_H_DEF;
	localparam int     OUT_W   = (MAX_W - 1) * 2 + 3;
	localparam int     OUT_H   = (MAX_H - 1) * 2 + 3;
	localparam longint SUM_MAX = (longint'(1) <<< 47) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	bit                               stride2;
	logic        [dds_pkg::DIM_W-1:0] width_reg;
	logic        [dds_pkg::DIM_W-1:0] height_reg;
	logic signed [dds_pkg::WGT_W-1:0] kernel [dds_pkg::TAPS];
	longint                           out_acc [OUT_H * OUT_W];
	int                               pix_row;
	int                               pix_col;
	read_result_t                     pending_reads [$];
	int                               errors;

	function new();
		stride2    = 1'b0;
		width_reg  = dds_pkg::DIM_RST;
		height_reg = dds_pkg::DIM_RST;
		foreach (kernel[k]) kernel[k] = '0;
		foreach (out_acc[a]) out_acc[a] = 0;
		pix_row = 0;
		pix_col = 0;
		errors  = 0;
	endfunction

	// Zero acts as one, anything past the limit as the limit
	function int clamp_dim(logic [dds_pkg::DIM_W-1:0] v, int lim);
		if (v == 0) return 1;
		if (int'(v) > lim) return lim;
		return int'(v);
	endfunction

	function int img_w();
		return clamp_dim(width_reg, MAX_W);
	endfunction

	function int img_h();
		return clamp_dim(height_reg, MAX_H);
	endfunction

	function int step();
		return stride2 ? 2 : 1;
	endfunction

	function int out_rows();
		return (img_h() - 1) * step() + 3;
	endfunction

	function int out_cols();
		return (img_w() - 1) * step() + 3;
	endfunction

	function int pending();
		return pending_reads.size();
	endfunction

	function void write_reg(logic [dds_pkg::CFG_IDX_W-1:0] idx,
			logic [dds_pkg::CFG_DATA_W-1:0] data);
		bit hit;
		hit = 1'b1;
		case (idx)
		dds_pkg::CFG_STRIDE: stride2 = data[0];
		dds_pkg::CFG_WIDTH:  width_reg = data;
		dds_pkg::CFG_HEIGHT: height_reg = data;
		default: hit = 1'b0;
		endcase
		// any real register write restarts the raster
		if (hit) begin
			pix_row = 0;
			pix_col = 0;
		end
	endfunction

	// Scatter one pixel over its 3x3 output window, saturating each sum
	function void scatter_pixel(logic signed [dds_pkg::PIX_W-1:0] pix);
		int     w, h, s, r, c, orow, ocol, a;
		longint sum;
		w = img_w();
		h = img_h();
		s = step();
		if (pix_row >= h || pix_col >= w) begin
			pix_row = 0;
			pix_col = 0;
		end
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				orow = pix_row * s + r;
				ocol = pix_col * s + c;
				if (orow < OUT_H && ocol < OUT_W) begin
					a   = orow * OUT_W + ocol;
					sum = out_acc[a] + longint'(pix) * longint'(kernel[r * 3 + c]);
					if (sum > SUM_MAX) sum = SUM_MAX;
					if (sum < SUM_MIN) sum = SUM_MIN;
					out_acc[a] = sum;
				end
			end
		end
		// advance the raster, wrapping at the end of the image
		pix_col++;
		if (pix_col >= w) begin
			pix_col = 0;
			pix_row++;
			if (pix_row >= h) pix_row = 0;
		end
	endfunction

	function void note_request(req_beat_t b);
		read_result_t res;
		int           a;
		case (b.action)
		dds_pkg::ACT_LOAD: begin
			if (b.weight_index < dds_pkg::TAPS) kernel[b.weight_index] = b.weight_value;
		end
		dds_pkg::ACT_ACC: scatter_pixel(b.pixel_value);
		dds_pkg::ACT_READ: begin
			if (int'(b.read_row) >= out_rows() || int'(b.read_col) >= out_cols()) begin
				res.value       = '0;
				res.range_error = 1'b1;
			end else begin
				a               = int'(b.read_row) * OUT_W + int'(b.read_col);
				res.value       = out_acc[a][dds_pkg::ACC_W-1:0];
				res.range_error = 1'b0;
				out_acc[a]      = 0;
			end
			pending_reads.push_back(res);
		end
		default: ;
		endcase
	endfunction

	task report(string msg);
		if (errors < 200) $display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	task check_response(logic signed [dds_pkg::ACC_W-1:0] value, logic range_error);
		read_result_t want;
		if (pending_reads.size() == 0) begin
			report($sformatf("read beat with none outstanding: value %0d range_error %b",
				value, range_error));
		end else begin
			want = pending_reads.pop_front();
			if (range_error !== want.range_error)
				report($sformatf("range_error %b, want %b", range_error, want.range_error));
			if (value !== want.value)
				report($sformatf("out_value %0d, want %0d", value, want.value));
		end
	endtask
endclass

module depthwise_deconv_3x3_scatter_top_tb;
	import dds_pkg::*;

	localparam int                   CLK_PERIOD    = 10;
	localparam int                   RANDOM_ITEMS  = 1750;
	localparam int                   SETTLE_CYCLES = 16;
	localparam int                   CYCLE_LIMIT   = 400000;
	localparam int                   IDLE_PCT      = 32;
	localparam logic [ACT_W-1:0]     ACT_NONE      = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

	logic clk;
	logic arst_n;

	dds_cfg_if cfg ();
	dds_req_if req ();
	dds_rsp_if rsp ();

	deconv_scoreboard sb;
	int               cycles = 0;
	int               useful = 0;
	bit               steady = 1'b0;

	depthwise_deconv_3x3_scatter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[depthwise_deconv_3x3_scatter_top] ERROR");
			$finish;
		end
	end

	// Stall the response side at random and check every accepted beat
	always @(posedge clk) begin
		rsp.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_response(rsp.out_value, rsp.range_error);
	end

	// Present one request beat after a random gap and hold it until accepted
	task automatic drive_req(input req_beat_t b);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req.valid        <= 1'b1;
		req.action       <= b.action;
		req.weight_index <= b.weight_index;
		req.weight_value <= b.weight_value;
		req.pixel_value  <= b.pixel_value;
		req.read_row     <= b.read_row;
		req.read_col     <= b.read_col;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(b);
		if (!(b.action == ACT_NONE || (b.action == ACT_LOAD && b.weight_index >= TAPS)))
			useful++;
		steady = (useful >= 700 && useful < 1050);
	endtask

	// Fill every field at random; the action decides which ones matter
	function automatic req_beat_t random_beat(logic [ACT_W-1:0] act);
		req_beat_t b;
		b.action       = act;
		b.weight_index = WIDX_W'($urandom);
		b.weight_value = WGT_W'($urandom);
		b.pixel_value  = PIX_W'($urandom);
		b.read_row     = RC_W'($urandom);
		b.read_col     = RC_W'($urandom);
		return b;
	endfunction

	task automatic send_load(int idx, logic signed [WGT_W-1:0] v);
		req_beat_t b;
		b              = random_beat(ACT_LOAD);
		b.weight_index = WIDX_W'(idx);
		b.weight_value = v;
		drive_req(b);
	endtask

	task automatic send_pixel(logic signed [PIX_W-1:0] v);
		req_beat_t b;
		b             = random_beat(ACT_ACC);
		b.pixel_value = v;
		drive_req(b);
	endtask

	task automatic send_read(int row, int col);
		req_beat_t b;
		b          = random_beat(ACT_READ);
		b.read_row = RC_W'(row);
		b.read_col = RC_W'(col);
		drive_req(b);
	endtask

	task automatic send_noise();
		drive_req(random_beat(ACT_NONE));
	endtask

	// Extremes now and then, otherwise any 16-bit value
	function automatic logic signed [PIX_W-1:0] pick_sample();
		case ($urandom_range(0, 15))
		0: return 16'sh8000;
		1: return 16'sh7FFF;
		2: return '0;
		default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim_extreme();
		case ($urandom_range(0, 3))
		0: return '0;
		1: return DIM_W'(1);
		2: return DIM_W'(MAX_IN_W_DEF);
		default: return DIM_W'($urandom_range(MAX_IN_W_DEF + 1, (1 << DIM_W) - 1));
		endcase
	endfunction

	// Drop valid, wait out every read beat, then let a pixel pass finish
	task automatic settle();
		req.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		sb.write_reg(idx, data);
	endtask

	// Write all three registers in a random order
	task automatic configure(logic [CFG_DATA_W-1:0] stride_data, logic [CFG_DATA_W-1:0] w,
			logic [CFG_DATA_W-1:0] h, bit spare);
		int first, k;
		first = $urandom_range(0, 2);
		// the spare index holds no register and must leave the raster alone
		if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
		for (k = 0; k < 3; k++) begin
			case ((first + k) % 3)
			0: write_reg(CFG_STRIDE, stride_data);
			1: write_reg(CFG_WIDTH, w);
			default: write_reg(CFG_HEIGHT, h);
			endcase
		end
		cfg.valid <= 1'b0;
	endtask

	initial begin
		int               w, h, oh, ow, n_pix, n_ch, ch, k, r, c, base;
		logic [DIM_W-1:0] w_reg, h_reg;
		sb = new();
		arst_n           <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.index        <= '0;
		cfg.data         <= '0;
		req.valid        <= 1'b0;
		req.action       <= '0;
		req.weight_index <= '0;
		req.weight_value <= '0;
		req.pixel_value  <= '0;
		req.read_row     <= '0;
		req.read_col     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// hold off through the accumulator clearing pass
		do @(posedge clk); while (req.ready !== 1'b1);

		// Stride 2, 2x1 image: extreme weights, ignored loads, wrap into a new channel
		configure(6'h21, 6'd2, 6'd1, 1'b0);
		send_load(0, 16'sh8000);
		send_load(4, 16'sh7FFF);
		send_load(TAP_LAST, -16'sd1);
		send_load(TAPS, 16'sd1234);
		send_load((1 << WIDX_W) - 1, -16'sd5);
		send_noise();
		send_pixel(16'sh8000);
		send_pixel(16'sh7FFF);
		send_pixel(16'sd256);
		send_read(0, 0);
		send_read(0, 0);
		send_read(2, 4);
		send_read(3, 0);
		send_read(0, 5);
		send_read((1 << RC_W) - 1, (1 << RC_W) - 1);
		settle();

		// Stride 1: a register write in mid-image restarts the raster
		configure(6'h3E, 6'd3, 6'd2, 1'b0);
		send_pixel(16'sd100);
		send_pixel(-16'sd200);
		settle();
		write_reg(CFG_WIDTH, 6'd3);
		cfg.valid <= 1'b0;
		send_pixel(16'sd7);
		send_read(0, 0);
		send_read(1, 1);
		settle();

		// Width past the limit and zero height: widest single-row output
		configure(6'h01, 6'h3F, 6'd0, 1'b1);
		send_read(2, 64);
		send_read(2, 65);
		send_read(3, 0);

		// Random phases: configure, stream channels, drain the output
		base = useful;
		while (useful - base < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 11))
			0: begin
				w_reg = pick_dim_extreme();
				h_reg = DIM_W'($urandom_range(1, 3));
			end
			1: begin
				h_reg = pick_dim_extreme();
				w_reg = DIM_W'($urandom_range(1, 3));
			end
			default: begin
				w_reg = DIM_W'($urandom_range(1, 5));
				h_reg = DIM_W'($urandom_range(1, 5));
			end
			endcase
			configure(CFG_DATA_W'($urandom), w_reg, h_reg, $urandom_range(0, 5) == 0);
			w    = sb.img_w();
			h    = sb.img_h();
			n_ch = $urandom_range(1, 3);
			for (ch = 0; ch < n_ch; ch++) begin
				// fresh kernel for the first channel, often for later ones
				if (ch == 0 || $urandom_range(0, 1)) begin
					for (k = 0; k < TAPS; k++) begin
						if ($urandom_range(0, 9) == 0)
							send_load($urandom_range(TAPS, (1 << WIDX_W) - 1), pick_sample());
						send_load(k, pick_sample());
					end
				end
				// now and then a cut-short or overlong channel
				n_pix = w * h;
				if ($urandom_range(0, 9) == 0) n_pix = $urandom_range(1, w * h + 2);
				for (k = 0; k < n_pix; k++) begin
					if ($urandom_range(0, 19) == 0) send_noise();
					if ($urandom_range(0, 29) == 0)
						send_read($urandom_range(0, sb.out_rows() - 1),
							$urandom_range(0, sb.out_cols() - 1));
					send_pixel(pick_sample());
				end
			end
			// drain most of the time; otherwise let sums carry into the next phase
			if ($urandom_range(0, 7) != 0) begin
				oh = sb.out_rows();
				ow = sb.out_cols();
				if (oh * ow <= 64) begin
					for (r = 0; r < oh; r++)
						for (c = 0; c < ow; c++)
							send_read(r, c);
				end else begin
					repeat (40) send_read($urandom_range(0, oh - 1), $urandom_range(0, ow - 1));
				end
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1))
						send_read($urandom_range(oh, (1 << RC_W) - 1),
							$urandom_range(0, (1 << RC_W) - 1));
					else
						send_read($urandom_range(0, (1 << RC_W) - 1),
							$urandom_range(ow, (1 << RC_W) - 1));
				end
			end
		end

		settle();
		if (sb.errors == 0) begin
			$display("[depthwise_deconv_3x3_scatter_top] OK");
		end else begin
			$display("[depthwise_deconv_3x3_scatter_top] ERROR");
		end
		$finish;
	end

endmodule
